FILE: rtl/psmp_pkg.sv
`default_nettype none
package psmp_pkg;
    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        K_TICK  = 3'd0,
        K_ADD   = 3'd1,
        K_WAIT  = 3'd2,
        K_EVENT = 3'd3,
        K_SHOW  = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        POL_FCFS = 2'd0,
        POL_SJF  = 2'd1,
        POL_RR   = 2'd2,
        POL_PRIO = 2'd3
    } t_policy;

    localparam logic REG_POLICY  = 1'b0;
    localparam logic REG_QUANTUM = 1'b1;

    typedef struct packed {
        logic [7:0]  prio;
        logic [15:0] rtime;
        logic [7:0]  id;
    } t_entry;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  proc_id;
        logic [15:0] run_time;
        logic [7:0]  priority_req;
        logic        then_tick;
    } t_in;

    typedef struct packed {
        logic        running_valid;
        logic [7:0]  running_id;
        logic [15:0] remaining_time;
    } t_out;
endpackage
`default_nettype wire

FILE: rtl/process_scheduler_multi_policy_core.sv
// multi-policy process scheduler: one running process, an arrival-ordered ready
// queue and a waiting set of TABLE_DEPTH entries each. an input transfer is
// taken only while the sequencer is idle. an add without tick is written in
// the accepting cycle and a show passes through the show state, then waits for
// its result transfer; wait and event scan the waiting set one slot a cycle
// and then run a tick. a tick scans the ready queue one entry a cycle through
// a single shared compare unit (fcfs and round robin take the head without a
// scan), then decides; removing the chosen entry shifts the queue one slot a
// cycle and an optional push follows.
// a show result waits in an output register; the next transfer is taken
// once that result has been transferred. configuration writes are taken only
// while the sequencer is idle. no clearing pass after reset.
`default_nettype none
module process_scheduler_multi_policy_core (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_ready,
    input  psmp_pkg::t_in    i_data,
    output logic             o_valid,
    input  wire              i_ready,
    output psmp_pkg::t_out   o_data,
    input  wire              i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire  [0:0]       i_cfg_index,
    input  wire  [15:0]      i_cfg_data
);
    import psmp_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_WSCAN = 8'b0000_0010, // wait: find free waiting slot
        S_ESCAN = 8'b0000_0100, // event: find matching waiting slot
        S_TSCAN = 8'b0000_1000, // tick: min/max search over ready queue
        S_TDEC  = 8'b0001_0000, // tick: decide
        S_SHIFT = 8'b0010_0000, // remove entry, close gap
        S_PUSH  = 8'b0100_0000, // optional push of old running entry
        S_SHOW  = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_entry r_ready [TABLE_DEPTH];
    t_entry r_wait  [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] r_wvalid;
    logic [CNT_W-1:0] r_rcount;
    logic        r_run_valid;
    t_entry      r_run;
    logic [15:0] r_slice;
    t_policy     r_policy;
    logic [15:0] r_quantum;
    logic [CNT_W-1:0] r_idx;   // scan / shift pointer
    logic [IDX_W-1:0] r_best;
    t_entry      r_best_e;
    t_entry      r_old;        // entry to push after removal
    logic        r_push;
    t_in         r_in;
    logic        r_oval;
    t_out        r_out;

    wire [IDX_W-1:0] w_idx = r_idx[IDX_W-1:0];
    wire t_entry w_cur = r_ready[w_idx];
    wire w_full = (r_rcount == CNT_W'(TABLE_DEPTH));
    wire w_has = (r_rcount != '0);
    // shared compare unit for the queue search
    wire w_better = (r_policy == POL_SJF) ? (w_cur.rtime < r_best_e.rtime)
                                          : (w_cur.prio > r_best_e.prio);
    wire t_entry w_dec = '{prio: r_run.prio, rtime: r_run.rtime - 16'd1, id: r_run.id};

    assign o_ready     = (r_state == S_IDLE) && !r_oval;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_valid     = r_oval;
    assign o_data      = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wvalid <= '0;
            r_rcount <= '0;
            r_run_valid <= 1'b0;
            r_slice <= '0;
            r_policy <= POL_FCFS;
            r_quantum <= 16'd4;
            r_oval <= 1'b0;
            r_push <= 1'b0;
            r_idx <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index[0])
                    REG_POLICY:  r_policy  <= t_policy'(i_cfg_data[1:0]);
                    REG_QUANTUM: r_quantum <= i_cfg_data;
                endcase
            end
            if (r_oval && i_ready) r_oval <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_in <= i_data;
                        r_idx <= '0;
                        unique case (i_data.kind)
                            K_TICK: r_state <= S_TSCAN;
                            K_ADD: begin
                                if (i_data.run_time != 16'd0 && !w_full) begin
                                    r_ready[r_rcount[IDX_W-1:0]] <= '{prio: i_data.priority_req,
                                        rtime: i_data.run_time, id: i_data.proc_id};
                                    r_rcount <= r_rcount + CNT_W'(1);
                                end
                                if (i_data.then_tick) r_state <= S_TSCAN;
                            end
                            K_WAIT:  r_state <= r_run_valid ? S_WSCAN : S_TSCAN;
                            K_EVENT: r_state <= S_ESCAN;
                            K_SHOW:  r_state <= S_SHOW;
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_SHOW: begin
                    r_oval <= 1'b1;
                    r_out.running_valid  <= r_run_valid;
                    r_out.running_id     <= r_run_valid ? r_run.id : 8'd0;
                    r_out.remaining_time <= r_run_valid ? r_run.rtime : 16'd0;
                    r_state <= S_IDLE;
                end
                S_WSCAN: begin
                    if (!r_wvalid[w_idx]) begin
                        r_wait[w_idx] <= r_run;
                        r_wvalid[w_idx] <= 1'b1;
                        r_run_valid <= 1'b0;
                        r_idx <= '0;
                        r_state <= S_TSCAN;
                    end else if (r_idx == CNT_W'(TABLE_DEPTH - 1)) begin
                        r_idx <= '0;
                        r_state <= S_TSCAN;
                    end else r_idx <= r_idx + CNT_W'(1);
                end
                S_ESCAN: begin
                    if (r_wvalid[w_idx] && r_wait[w_idx].id == r_in.proc_id) begin
                        if (!w_full) begin
                            r_ready[r_rcount[IDX_W-1:0]] <= r_wait[w_idx];
                            r_rcount <= r_rcount + CNT_W'(1);
                            r_wvalid[w_idx] <= 1'b0;
                        end
                        r_idx <= '0;
                        r_state <= S_TSCAN;
                    end else if (r_idx == CNT_W'(TABLE_DEPTH - 1)) begin
                        r_idx <= '0;
                        r_state <= S_TSCAN;
                    end else r_idx <= r_idx + CNT_W'(1);
                end
                S_TSCAN: begin
                    // fcfs and rr always pick the head
                    if (r_idx == '0) begin
                        r_best <= '0;
                        r_best_e <= r_ready[0];
                        if ((r_policy == POL_SJF || r_policy == POL_PRIO)
                            && r_rcount > CNT_W'(1)) begin
                            r_idx <= CNT_W'(1);
                        end else begin
                            r_state <= S_TDEC;
                        end
                    end else begin
                        if (w_better) begin
                            r_best <= w_idx;
                            r_best_e <= w_cur;
                        end
                        if (r_idx + CNT_W'(1) >= r_rcount) r_state <= S_TDEC;
                        else r_idx <= r_idx + CNT_W'(1);
                    end
                end
                S_TDEC: begin
                    logic        v_cnt;
                    t_entry      v_e;
                    logic [15:0] v_sl;
                    t_entry      v_run;
                    t_entry      v_old;
                    logic        v_run_valid;
                    logic        v_push;
                    logic        v_take;
                    logic [15:0] v_slice;
                    // priority mode counts down only inside the slice
                    v_cnt = r_slice < r_quantum;
                    v_e = v_cnt ? w_dec : r_run;
                    v_sl = v_cnt ? r_slice + 16'd1 : r_slice;
                    v_run = r_run;
                    v_run_valid = r_run_valid;
                    v_slice = r_slice;
                    v_old = w_dec;
                    v_push = 1'b0;
                    v_take = 1'b0;
                    unique case (r_policy)
                        POL_FCFS, POL_SJF: begin
                            if (r_run_valid && w_dec.rtime != 16'd0) v_run = w_dec;
                            else begin
                                v_run_valid = 1'b0;
                                v_take = w_has;
                            end
                        end
                        POL_RR: begin
                            if (!r_run_valid) begin
                                v_take = w_has;
                                if (w_has) v_slice = '0;
                            end else if (w_dec.rtime == 16'd0) begin
                                v_slice = '0;
                                v_run_valid = 1'b0;
                                v_take = w_has;
                            end else if (r_slice + 16'd1 == r_quantum) begin
                                // rotate to the back, or keep running if alone
                                v_slice = '0;
                                v_run = w_dec;
                                v_old = w_dec;
                                v_push = w_has;
                                v_take = w_has;
                            end else begin
                                v_run = w_dec;
                                v_slice = r_slice + 16'd1;
                            end
                        end
                        POL_PRIO: begin
                            if (!r_run_valid) begin
                                v_take = w_has;
                                if (w_has) v_slice = '0;
                            end else if (w_has && r_run.prio < r_best_e.prio) begin
                                // preemption: old entry loses one tick
                                v_old = w_dec;
                                v_push = (w_dec.rtime != 16'd0);
                                v_take = 1'b1;
                                v_slice = '0;
                            end else if (v_e.rtime == 16'd0) begin
                                v_slice = '0;
                                v_run_valid = 1'b0;
                                v_run = v_e;
                                v_take = w_has;
                            end else if (v_sl == r_quantum) begin
                                // slice end rotates only against an equal peer
                                v_slice = '0;
                                v_run = v_e;
                                v_old = v_e;
                                v_push = w_has && (v_e.prio == r_best_e.prio);
                                v_take = v_push;
                            end else begin
                                v_run = v_e;
                                v_slice = v_sl;
                            end
                        end
                    endcase
                    if (v_take) begin
                        v_run = r_best_e;
                        v_run_valid = 1'b1;
                    end
                    r_run <= v_run;
                    r_run_valid <= v_run_valid;
                    r_slice <= v_slice;
                    r_old <= v_old;
                    r_push <= v_push;
                    r_idx <= {1'b0, r_best};
                    r_state <= v_take ? S_SHIFT : S_IDLE;
                end
                S_SHIFT: begin
                    // close the gap one slot a cycle
                    if (r_idx + CNT_W'(1) < r_rcount) begin
                        r_ready[w_idx] <= r_ready[IDX_W'(r_idx + CNT_W'(1))];
                        r_idx <= r_idx + CNT_W'(1);
                    end else begin
                        r_rcount <= r_rcount - CNT_W'(1);
                        r_state <= r_push ? S_PUSH : S_IDLE;
                    end
                end
                S_PUSH: begin
                    if (!w_full) begin
                        r_ready[r_rcount[IDX_W-1:0]] <= r_old;
                        r_rcount <= r_rcount + CNT_W'(1);
                    end
                    r_push <= 1'b0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rcount <= CNT_W'(TABLE_DEPTH)) else $error("ready count overflow");
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> r_state == S_IDLE) else $error("ready while busy");
    a_show_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SHOW |=> r_oval) else $error("show lost");
    a_push_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_PUSH |-> $past(r_state) == S_SHIFT) else $error("bad push");
`endif
endmodule
`default_nettype wire
